// ===== hw/rtl/osbc_pkg.sv =====
// Shared constants, input operation codes and the MAC control word type
// for the overlap-save block convolver. No dependencies.
package osbc_pkg;

   localparam int MAX_TAPS_DEF  = 32;
   localparam int MAX_BLOCK_DEF = 64;

   localparam int VALUE_W  = 16;
   localparam int PROD_W   = 32;
   localparam int RESULT_W = 37;
   localparam int OP_W     = 2;
   localparam int IDX_W    = 5;
   localparam int KLEN_W   = 6;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
      logic smp_ok;
   } mac_ctl_type;

endpackage

// ===== hw/rtl/overlap_save_block_convolver_unit.sv =====
// Overlap-save block convolver: sequencer, history and tap memories, shared MAC.
// Depends on osbc_pkg, osbc_tap_store, osbc_hist_store and osbc_mac.
//
// When a push completes a group of G samples (G = B - K + 1, B the smallest power
// of two at least 2K), the block stops taking words and emits the G results on
// the single multiply-accumulate, each from K tap reads through three pipeline
// stages, after a setup step per group; a flush of a partly filled group first
// pads it with zeros. A result register lets the next word enter while a result
// waits. Tap loads and kernel_length writes clear the history at once through a
// count of samples held, so there is no clearing pass.
module overlap_save_block_convolver_unit #(
   parameter int MAX_TAPS  = osbc_pkg::MAX_TAPS_DEF,
   parameter int MAX_BLOCK = osbc_pkg::MAX_BLOCK_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [osbc_pkg::OP_W-1:0]            req_operation,
   input  logic [osbc_pkg::IDX_W-1:0]           req_tap_index,
   input  logic signed [osbc_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [osbc_pkg::RESULT_W-1:0] rsp_result,
   output logic                                 rsp_last,
   input  logic                                 csr_wr_en,
   input  logic [osbc_pkg::KLEN_W-1:0]          csr_wr_data
);

   localparam int TW   = $clog2(MAX_TAPS);
   localparam int AW   = $clog2(MAX_BLOCK);
   localparam int HCW  = $clog2(MAX_BLOCK + 1);
   localparam int KMAX = (MAX_TAPS < MAX_BLOCK / 2) ? MAX_TAPS : MAX_BLOCK / 2;
   localparam int KW   = $clog2(KMAX + 1);
   localparam int BLW  = $clog2(KW + 1);
   localparam int BW   = KW + 2;
   localparam int SW   = ((BW > AW + 1) ? BW : AW + 1) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_SETUP,
      S_ISSUE,
      S_DRAIN
   } state_type;

   state_type                            state_ff;
   logic [osbc_pkg::KLEN_W-1:0]          klen_ff;
   logic [AW-1:0]                        wp_ff;
   logic [BW-1:0]                        fill_ff;
   logic [HCW-1:0]                       hcnt_ff;
   logic [AW-1:0]                        eage_ff;
   logic [AW-1:0]                        saddr_ff;
   logic [AW-1:0]                        ea_ff;
   logic [AW-1:0]                        raddr_ff;
   logic [TW-1:0]                        tcnt_ff;
   logic [BW-1:0]                        ocnt_ff;
   logic                                 rsp_valid_ff;
   logic signed [osbc_pkg::RESULT_W-1:0] rsp_result_ff;
   logic                                 rsp_last_ff;

   logic [KW-1:0]                        kact;
   logic [KW-1:0]                        km1;
   logic [BLW-1:0]                       blen;
   logic [BW-1:0]                        bsize;
   logic [BW-1:0]                        grp;
   logic [SW-1:0]                        e_w;
   logic [SW-1:0]                        s_w;
   logic [AW-1:0]                        wp_step;
   logic [AW-1:0]                        ea_step;
   logic [AW-1:0]                        raddr_step;
   logic [AW-1:0]                        eage_step;
   logic [AW-1:0]                        saddr_step;
   logic [BW-1:0]                        fill_step;
   logic [HCW-1:0]                       hcnt_step;
   logic                                 accept;
   logic                                 idx_ok;
   logic                                 tap_last;
   logic                                 out_last;
   logic                                 out_free;
   logic                                 take;
   logic                                 hist_we;
   logic signed [osbc_pkg::VALUE_W-1:0]  hist_wdata;
   logic                                 tap_we;
   logic signed [osbc_pkg::VALUE_W-1:0]  tap_rdata;
   logic signed [osbc_pkg::VALUE_W-1:0]  hist_rdata;
   logic signed [osbc_pkg::RESULT_W-1:0] mac_acc;
   logic                                 mac_done;
   osbc_pkg::mac_ctl_type                mac_ctl;

   always_comb begin
      if (klen_ff == '0) begin
         kact = KW'(1);
      end else if (32'(klen_ff) > KMAX) begin
         kact = KW'(KMAX);
      end else begin
         kact = KW'(klen_ff);
      end
   end

   assign km1 = kact - KW'(1);

   always_comb begin
      blen = '0;
      for (int i = 0; i < KW; i++) begin
         if (km1[i]) begin
            blen = BLW'(i + 1);
         end
      end
   end

   assign bsize = BW'(2) << blen;
   assign grp   = bsize - BW'(kact) + BW'(1);

   always_comb begin
      e_w = SW'(grp) - SW'(1);
      if (e_w >= SW'(MAX_BLOCK)) begin
         e_w = e_w - SW'(MAX_BLOCK);
      end
      s_w = SW'(wp_ff) + SW'(MAX_BLOCK) - SW'(1) - e_w;
      if (s_w >= SW'(MAX_BLOCK)) begin
         s_w = s_w - SW'(MAX_BLOCK);
      end
   end

   assign wp_step    = (wp_ff == AW'(MAX_BLOCK - 1)) ? '0 : wp_ff + AW'(1);
   assign ea_step    = (ea_ff == AW'(MAX_BLOCK - 1)) ? '0 : ea_ff + AW'(1);
   assign raddr_step = (raddr_ff == '0) ? AW'(MAX_BLOCK - 1) : raddr_ff - AW'(1);
   assign eage_step  = (eage_ff == '0) ? AW'(MAX_BLOCK - 1) : eage_ff - AW'(1);
   assign saddr_step = (saddr_ff == AW'(MAX_BLOCK - 1)) ? '0 : saddr_ff + AW'(1);
   assign fill_step  = fill_ff + BW'(1);
   assign hcnt_step  = (hcnt_ff == HCW'(MAX_BLOCK)) ? hcnt_ff : hcnt_ff + HCW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_ok    = 32'(req_tap_index) < MAX_TAPS;
   assign tap_last  = 32'(tcnt_ff) == 32'(kact) - 32'd1;
   assign out_last  = ocnt_ff == grp - BW'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = (state_ff == S_DRAIN) && mac_done && out_free;

   assign hist_we    = (accept && req_operation == osbc_pkg::OP_PUSH) || (state_ff == S_PAD);
   assign hist_wdata = (state_ff == S_PAD) ? '0 : req_value;
   assign tap_we     = accept && req_operation == osbc_pkg::OP_LOAD && idx_ok;

   assign mac_ctl.vld    = (state_ff == S_ISSUE);
   assign mac_ctl.first  = (tcnt_ff == '0);
   assign mac_ctl.last   = tap_last;
   assign mac_ctl.smp_ok = HCW'(ea_ff) < hcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         klen_ff      <= osbc_pkg::KLEN_W'(1);
         wp_ff        <= '0;
         fill_ff      <= '0;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            klen_ff <= csr_wr_data;
            wp_ff   <= '0;
            fill_ff <= '0;
            hcnt_ff <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_operation)
                     osbc_pkg::OP_PUSH: begin
                        wp_ff   <= wp_step;
                        fill_ff <= fill_step;
                        hcnt_ff <= hcnt_step;
                        if (fill_step >= grp) begin
                           state_ff <= S_SETUP;
                        end
                     end
                     osbc_pkg::OP_LOAD: begin
                        if (idx_ok) begin
                           wp_ff   <= '0;
                           fill_ff <= '0;
                           hcnt_ff <= '0;
                        end
                     end
                     osbc_pkg::OP_FLUSH: begin
                        if (fill_ff != '0) begin
                           state_ff <= (fill_ff >= grp) ? S_SETUP : S_PAD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_PAD: begin
               wp_ff   <= wp_step;
               fill_ff <= fill_step;
               hcnt_ff <= hcnt_step;
               if (fill_step >= grp) begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               fill_ff  <= '0;
               eage_ff  <= AW'(e_w);
               saddr_ff <= AW'(s_w);
               ea_ff    <= AW'(e_w);
               raddr_ff <= AW'(s_w);
               tcnt_ff  <= '0;
               ocnt_ff  <= '0;
               state_ff <= S_ISSUE;
            end
            S_ISSUE: begin
               tcnt_ff  <= tcnt_ff + TW'(1);
               ea_ff    <= ea_step;
               raddr_ff <= raddr_step;
               if (tap_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (take) begin
                  rsp_result_ff <= mac_acc;
                  rsp_last_ff   <= out_last;
                  if (out_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     eage_ff  <= eage_step;
                     saddr_ff <= saddr_step;
                     ea_ff    <= eage_step;
                     raddr_ff <= saddr_step;
                     tcnt_ff  <= '0;
                     ocnt_ff  <= ocnt_ff + BW'(1);
                     state_ff <= S_ISSUE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   osbc_tap_store #(
      .MAX_TAPS (MAX_TAPS)
   ) u_taps (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tap_we),
      .wr_addr (TW'(req_tap_index)),
      .wr_data (req_value),
      .rd_addr (tcnt_ff),
      .rd_data (tap_rdata)
   );

   osbc_hist_store #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wp_ff),
      .wr_data (hist_wdata),
      .rd_addr (raddr_ff),
      .rd_data (hist_rdata)
   );

   osbc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .tap_data (tap_rdata),
      .smp_data (hist_rdata),
      .take     (take),
      .acc      (mac_acc),
      .done     (mac_done)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hw/rtl/osbc_tap_store.sv =====
// Kernel tap memory with per-entry valid bits; unwritten taps read as zero.
// Depends on osbc_pkg.
module osbc_tap_store #(
   parameter int MAX_TAPS = osbc_pkg::MAX_TAPS_DEF,
   localparam int TW = $clog2(MAX_TAPS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [TW-1:0]                       wr_addr,
   input  logic signed [osbc_pkg::VALUE_W-1:0] wr_data,
   input  logic [TW-1:0]                       rd_addr,
   output logic signed [osbc_pkg::VALUE_W-1:0] rd_data
);

   logic signed [osbc_pkg::VALUE_W-1:0] mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]                 valid_ff;
   logic signed [osbc_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/osbc_hist_store.sv =====
// Circular sample history memory, one write and one registered read port.
// Depends on osbc_pkg.
module osbc_hist_store #(
   parameter int MAX_BLOCK = osbc_pkg::MAX_BLOCK_DEF,
   localparam int AW = $clog2(MAX_BLOCK)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [osbc_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [osbc_pkg::VALUE_W-1:0] rd_data
);

   logic signed [osbc_pkg::VALUE_W-1:0] mem [MAX_BLOCK];
   logic signed [osbc_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/osbc_mac.sv =====
// Shared multiply-accumulate: aligns control with memory read data, registers
// the 16x16 product, accumulates to 37 bits. Depends on osbc_pkg.
module osbc_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  osbc_pkg::mac_ctl_type                ctl,
   input  logic signed [osbc_pkg::VALUE_W-1:0]  tap_data,
   input  logic signed [osbc_pkg::VALUE_W-1:0]  smp_data,
   input  logic                                 take,
   output logic signed [osbc_pkg::RESULT_W-1:0] acc,
   output logic                                 done
);

   osbc_pkg::mac_ctl_type                ctl1_ff;
   osbc_pkg::mac_ctl_type                ctl2_ff;
   logic signed [osbc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [osbc_pkg::PROD_W-1:0]   prod_in;
   logic signed [osbc_pkg::RESULT_W-1:0] acc_ff;
   logic                                 done_ff;
   logic signed [osbc_pkg::RESULT_W-1:0] prod_ext;
   logic signed [osbc_pkg::RESULT_W-1:0] acc_base;

   assign prod_in  = tap_data * smp_data;
   assign prod_ext = osbc_pkg::RESULT_W'(prod_ff);
   assign acc_base = ctl2_ff.first ? '0 : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl1_ff <= ctl;
         ctl2_ff <= ctl1_ff;
         if (take) begin
            done_ff <= 1'b0;
         end
         if (ctl2_ff.vld && ctl2_ff.last) begin
            done_ff <= 1'b1;
         end
      end
      prod_ff <= ctl1_ff.smp_ok ? prod_in : '0;
      if (ctl2_ff.vld) begin
         acc_ff <= acc_base + prod_ext;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ===== sim/osbc_conv_checker.sv =====
`timescale 1ns / 100ps
// Checker for the overlap-save block convolver: tracks taps, sample history and kernel
// length from the observed words, predicts every convolution output and compares it.
// Depends on osbc_pkg.
module osbc_conv_checker
   import osbc_pkg::*;
#(
   parameter int MAX_TAPS  = MAX_TAPS_DEF,
   parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [OP_W-1:0]             req_operation,
   input  logic [IDX_W-1:0]            req_tap_index,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [RESULT_W-1:0]  rsp_result,
   input  logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [KLEN_W-1:0]           csr_wr_data,
   output int                          mismatch_count,
   output int                          pending_count
);

   typedef struct packed {
      logic signed [RESULT_W-1:0] sum;
      logic                       last;
   } conv_out_t;

   logic signed [VALUE_W-1:0] tap_coef [MAX_TAPS];
   logic signed [VALUE_W-1:0] sample_ring [MAX_BLOCK];
   int unsigned               group_fill;
   int unsigned               ring_wr_ptr;
   logic [KLEN_W-1:0]         kernel_len;
   conv_out_t                 conv_out_q [$];
   int                        errors = 0;

   function automatic int unsigned active_taps();
      int unsigned k;
      k = kernel_len;
      if (k < 1) k = 1;
      if (k > MAX_TAPS) k = MAX_TAPS;
      if (k > MAX_BLOCK / 2) k = MAX_BLOCK / 2;
      return k;
   endfunction

   function automatic int unsigned group_len(int unsigned k);
      int unsigned b;
      b = 1;
      while (b < 2 * k) b = b << 1;
      return b - k + 1;
   endfunction

   function automatic void clear_history();
      foreach (sample_ring[i]) sample_ring[i] = '0;
      group_fill  = 0;
      ring_wr_ptr = 0;
   endfunction

   function automatic void put_sample(logic signed [VALUE_W-1:0] s);
      sample_ring[ring_wr_ptr] = s;
      ring_wr_ptr = (ring_wr_ptr + 1) % MAX_BLOCK;
      group_fill++;
   endfunction

   function automatic void convolve_group(int unsigned k, int unsigned g);
      int unsigned age;
      int unsigned slot;
      longint      acc;
      conv_out_t   out_word;
      for (int unsigned i = 0; i < g; i++) begin
         age = g - 1 - i;
         acc = 0;
         for (int unsigned t = 0; t < k; t++) begin
            slot = (ring_wr_ptr + MAX_BLOCK - 1 - ((age + t) % MAX_BLOCK)) % MAX_BLOCK;
            acc += longint'(tap_coef[t]) * longint'(sample_ring[slot]);
         end
         out_word.sum  = RESULT_W'(acc);
         out_word.last = (i + 1 == g);
         conv_out_q.push_back(out_word);
      end
      group_fill = 0;
   endfunction

   function automatic void apply_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                      logic signed [VALUE_W-1:0] val);
      int unsigned k;
      int unsigned g;
      k = active_taps();
      g = group_len(k);
      case (op)
         OP_LOAD: begin
            if (idx < MAX_TAPS) begin
               tap_coef[idx] = val;
               clear_history();
            end
         end
         OP_PUSH: begin
            put_sample(val);
            if (group_fill >= g) convolve_group(k, g);
         end
         OP_FLUSH: begin
            if (group_fill != 0) begin
               while (group_fill < g) put_sample('0);
               convolve_group(k, g);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      conv_out_t want;
      if (reset) begin
         foreach (tap_coef[i]) tap_coef[i] = '0;
         clear_history();
         kernel_len = 1;
         conv_out_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (conv_out_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected word: result %0d last %0b",
                           $realtime, rsp_result, rsp_last);
            end else begin
               want = conv_out_q.pop_front();
               if (rsp_result !== want.sum || rsp_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected result %0d last %0b, got result %0d last %0b",
                              $realtime, $signed(want.sum), want.last, rsp_result, rsp_last);
               end
            end
         end
         if (csr_wr_en) begin
            kernel_len = csr_wr_data;
            clear_history();
         end
         if (req_valid && req_ready)
            apply_word(req_operation, req_tap_index, req_value);
      end
      pending_count  <= conv_out_q.size();
      mismatch_count <= errors;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the overlap-save block convolver testbench: clock, reset, stimulus and verdict.
// Depends on osbc_pkg, overlap_save_block_convolver_unit and osbc_conv_checker.
module tb_top;
   import osbc_pkg::*;

   localparam int              CYCLE_LIMIT = 4_000_000;
   localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [OP_W-1:0]            req_operation;
   logic [IDX_W-1:0]           req_tap_index;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_result;
   logic                       rsp_last;
   logic                       csr_wr_en;
   logic [KLEN_W-1:0]          csr_wr_data;
   int                         mismatch_count;
   int                         pending_count;
   int                         cycle_count = 0;
   int                         req_idle_pct = 10;
   int                         rsp_stall_pct = 10;

   overlap_save_block_convolver_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_tap_index (req_tap_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   osbc_conv_checker i_conv_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_tap_index  (req_tap_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result     (rsp_result),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_tap_index <= idx;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained(input int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_kernel_len(input logic [KLEN_W-1:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [KLEN_W-1:0] len_plan [$];
      int unsigned       taps_used;
      int unsigned       pick;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_PUSH;
      req_tap_index <= '0;
      req_value     <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset state: one zero tap, group of two
      send_word(OP_PUSH, 5'd0, 16'sh7FFF);
      send_word(OP_PUSH, 5'd31, 16'sh8000);
      wait_drained(8);
      write_kernel_len(6'd2);
      send_word(OP_FLUSH, 5'd0, '0);
      send_word(OP_NONE, 5'd31, 16'sh7FFF);
      send_word(OP_LOAD, 5'd0, 16'sh8000);
      send_word(OP_LOAD, 5'd1, 16'sh8000);
      send_word(OP_LOAD, 5'd31, 16'sh7FFF);
      send_word(OP_PUSH, 5'd0, 16'sh8000);
      send_word(OP_PUSH, 5'd0, 16'sh8000);
      send_word(OP_PUSH, 5'd0, 16'sh7FFF);
      send_word(OP_PUSH, 5'd0, 16'sh0001);
      send_word(OP_FLUSH, 5'd0, '0);
      send_word(OP_FLUSH, 5'd0, '0);
      send_word(OP_LOAD, 5'd1, 16'sh7FFF);
      send_word(OP_PUSH, 5'd0, 16'shFFFF);
      send_word(OP_NONE, IDX_W'($urandom), VALUE_W'($urandom));
      send_word(OP_FLUSH, 5'd0, '0);

      len_plan = '{6'd32, 6'd0, 6'd63, 6'd17, 6'd1, 6'd16, 6'd33,
                   KLEN_W'($urandom_range(2, 31)), KLEN_W'($urandom_range(2, 31)), 6'd3};
      foreach (len_plan[p]) begin
         wait_drained(8);
         req_idle_pct  = (p == 2) ? 0 : 10;
         rsp_stall_pct = (p == 2) ? 0 : 10;
         write_kernel_len(len_plan[p]);
         taps_used = (len_plan[p] == 0) ? 1 : (len_plan[p] > 32) ? 32 : len_plan[p];
         for (int unsigned t = 0; t < taps_used; t++)
            send_word(OP_LOAD, IDX_W'(t), pick_value());
         repeat (40) begin
            pick = $urandom_range(99);
            if (pick < 82)
               send_word(OP_PUSH, IDX_W'($urandom), pick_value());
            else if (pick < 89)
               send_word(OP_FLUSH, IDX_W'($urandom), VALUE_W'($urandom));
            else if (pick < 94)
               send_word(OP_LOAD, IDX_W'($urandom), pick_value());
            else
               send_word(OP_NONE, IDX_W'($urandom), VALUE_W'($urandom));
         end
         send_word(OP_FLUSH, '0, '0);
      end

      wait_drained(60);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/osbc_pkg.sv
hw/rtl/osbc_tap_store.sv
hw/rtl/osbc_hist_store.sv
hw/rtl/osbc_mac.sv
hw/rtl/overlap_save_block_convolver_unit.sv
sim/osbc_conv_checker.sv
sim/tb_top.sv
